// ===== rtl/pds_pkg.sv =====
// shared constants for the pll divider search block
package pds_pkg;

    // fixed field widths
    localparam int SLOT_W   = 2;
    localparam int TARGET_W = 19;
    localparam int VCO_W    = 20;
    localparam int REF_W    = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 20;

    // input tdata holds target_khz padded to whole bytes
    localparam int S_TDATA_W = ((TARGET_W + 7) / 8) * 8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VCO_MIN = 2'd0,
        REG_VCO_MAX = 2'd1,
        REG_REF_CLK = 2'd2
    } cfg_reg_t;

    // reset values of the configuration registers
    localparam logic [VCO_W-1:0] VCO_MIN_RST = VCO_W'(180000);
    localparam logic [VCO_W-1:0] VCO_MAX_RST = VCO_W'(360000);
    localparam logic [REF_W-1:0] REF_CLK_RST = REF_W'(14318);

endpackage

// ===== rtl/pll_divider_search_top.sv =====
// pll divider search: picks m, n and r for one clock slot per request
//
// One request enters at a time; s_tready stays low until the search is done. A request
// first scans r = 0..R_MAX, one compare per cycle, then for each n = 1..N_MAX runs up to
// two divisions on one shared restoring divider that produces one quotient bit per cycle:
// the rounded m quotient (TARGET_W + clog2(N_MAX+3) + R_MAX + 2 bits, 30 by default) and,
// if m is in range, the achieved frequency (REF_W + clog2(M_MAX+3) bits, 25 by default).
// The result sits in an output register, so the next request is taken while it waits; a
// finished search waits only if that register is still full. Configuration writes are taken
// in any cycle and must only come while idle.
module pll_divider_search_top #(
    parameter int N_MAX = 31,
    parameter int M_MAX = 127,
    parameter int R_MAX = 3
) (
    input  logic clk,
    input  logic rst_n,

    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pds_pkg::S_TDATA_W-1:0]     s_tdata,   // [18:0] target_khz
    input  logic [pds_pkg::SLOT_W-1:0]        s_tuser,   // [1:0] clock_slot

    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [((($clog2(M_MAX+1) + $clog2(N_MAX+1) + $clog2(R_MAX+2)
                    + pds_pkg::TARGET_W) + 7) / 8) * 8 - 1:0] m_tdata,
                    // mult_m, div_n, post_r, freq_error from the lowest bit up
    output logic [pds_pkg::SLOT_W-1:0]        m_tuser,   // [1:0] slot_out

    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pds_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int TGT_W  = pds_pkg::TARGET_W;
    localparam int REFW   = pds_pkg::REF_W;
    localparam int N_W    = $clog2(N_MAX + 1);
    localparam int NP_W   = $clog2(N_MAX + 3);
    localparam int M_W    = $clog2(M_MAX + 1);
    localparam int MP_W   = $clog2(M_MAX + 3);
    localparam int R_W    = $clog2(R_MAX + 2);
    localparam int SH_MAX = R_MAX + 1;
    localparam int A_W    = TGT_W + NP_W + SH_MAX + 1;
    localparam int B_W    = REFW + MP_W;
    localparam int DIV_W  = (A_W > B_W) ? A_W : B_W;
    localparam int D2_W   = NP_W + SH_MAX;
    localparam int DEN_W  = (REFW > D2_W) ? REFW : D2_W;
    localparam int CNT_W  = $clog2(DIV_W + 1);
    localparam int E_W    = (B_W > TGT_W) ? B_W : TGT_W;
    localparam int VS_W   = TGT_W + R_MAX;
    localparam int CMP_W  = (VS_W > pds_pkg::VCO_W) ? VS_W : pds_pkg::VCO_W;
    localparam int OUT_BITS = M_W + N_W + R_W + TGT_W;
    localparam int OUT_TD_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RSCAN,
        ST_PREP,
        ST_DIV1,
        ST_CHECK,
        ST_DIV2,
        ST_SCORE,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [pds_pkg::VCO_W-1:0] vco_min_reg;
    logic [pds_pkg::VCO_W-1:0] vco_max_reg;
    logic [REFW-1:0]           ref_clk_reg;

    // request and search registers
    logic [pds_pkg::SLOT_W-1:0] slot_reg;
    logic [TGT_W-1:0]           target_reg;
    logic [R_W-1:0]             r_reg;
    logic [N_W-1:0]             n_reg;
    logic [MP_W-1:0]            mp2_reg;
    logic [TGT_W-1:0]           best_err_reg;
    logic [M_W-1:0]             best_m_reg;
    logic [N_W-1:0]             best_n_reg;

    // shared divider registers
    logic [DIV_W-1:0] div_num_reg;
    logic [DEN_W-1:0] div_den_reg;
    logic [DEN_W-1:0] div_rem_reg;
    logic [CNT_W-1:0] div_cnt_reg;

    // output registers
    logic                       m_tvalid_reg;
    logic [pds_pkg::SLOT_W-1:0] out_slot_reg;
    logic [M_W-1:0]             out_m_reg;
    logic [N_W-1:0]             out_n_reg;
    logic [R_W-1:0]             out_r_reg;
    logic [TGT_W-1:0]           out_err_reg;

    logic                  s_xfer;
    logic [REFW-1:0]       ref_eff;
    logic [CMP_W-1:0]      vco_shift;
    logic                  vco_fit;
    logic [NP_W-1:0]       np2;
    logic [TGT_W+NP_W-1:0] prod_a;
    logic [A_W-1:0]        num_a;
    logic [A_W-1:0]        quot_a;
    logic                  m_in_range;
    logic [MP_W-1:0]       mp2_cand;
    logic [B_W-1:0]        num_b;
    logic [DEN_W-1:0]      den_b;
    logic [DEN_W:0]        div_shift;
    logic [DEN_W:0]        div_diff;
    logic                  div_bit;
    logic [E_W-1:0]        ach_e;
    logic [E_W-1:0]        tgt_e;
    logic [E_W-1:0]        err_e;
    logic                  err_better;
    logic                  out_free;

    assign s_xfer    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    // a zero reference counts as one
    assign ref_eff = (ref_clk_reg == '0) ? REFW'(1) : ref_clk_reg;

    // range check of target << r for the post divider scan
    assign vco_shift = CMP_W'(target_reg) << r_reg;
    assign vco_fit   = (vco_shift >= CMP_W'(vco_min_reg)) && (vco_shift < CMP_W'(vco_max_reg));

    // rounded m numerator: (target * (n + 2)) << r plus half the reference
    assign np2    = NP_W'(n_reg) + NP_W'(2);
    assign prod_a = (TGT_W+NP_W)'(target_reg) * (TGT_W+NP_W)'(np2);
    assign num_a  = (A_W'(prod_a) << r_reg) + A_W'(ref_eff >> 1);

    // quotient check and achieved frequency operands
    assign quot_a     = div_num_reg[A_W-1:0];
    assign m_in_range = (quot_a >= A_W'(2)) && (quot_a <= A_W'(M_MAX + 2));
    assign mp2_cand   = quot_a[MP_W-1:0];
    assign num_b      = B_W'(ref_eff) * B_W'(mp2_cand);
    assign den_b      = DEN_W'(D2_W'(np2) << r_reg);

    // one restoring divider step
    assign div_shift = {div_rem_reg, div_num_reg[DIV_W-1]};
    assign div_diff  = div_shift - {1'b0, div_den_reg};
    assign div_bit   = !div_diff[DEN_W];

    // absolute error of the achieved frequency
    assign ach_e      = E_W'(div_num_reg[B_W-1:0]);
    assign tgt_e      = E_W'(target_reg);
    assign err_e      = (tgt_e >= ach_e) ? (tgt_e - ach_e) : (ach_e - tgt_e);
    assign err_better = err_e < E_W'(best_err_reg);

    // sequencer, divider, configuration and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            vco_min_reg  <= pds_pkg::VCO_MIN_RST;
            vco_max_reg  <= pds_pkg::VCO_MAX_RST;
            ref_clk_reg  <= pds_pkg::REF_CLK_RST;
            slot_reg     <= '0;
            target_reg   <= '0;
            r_reg        <= '0;
            n_reg        <= N_W'(1);
            mp2_reg      <= '0;
            best_err_reg <= '0;
            best_m_reg   <= M_W'(1);
            best_n_reg   <= N_W'(1);
            div_num_reg  <= '0;
            div_den_reg  <= '0;
            div_rem_reg  <= '0;
            div_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            out_slot_reg <= '0;
            out_m_reg    <= '0;
            out_n_reg    <= '0;
            out_r_reg    <= '0;
            out_err_reg  <= '0;
        end
        else
        begin
            // configuration writes, unknown index ignored
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    pds_pkg::REG_VCO_MIN: vco_min_reg <= cfg_data;
                    pds_pkg::REG_VCO_MAX: vco_max_reg <= cfg_data;
                    pds_pkg::REG_REF_CLK: ref_clk_reg <= cfg_data[REFW-1:0];
                    default: ;
                endcase
            end

            // output transaction taken, a finishing search reloads the register itself
            if (m_tvalid_reg && m_tready && state_reg != ST_FINISH)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_xfer)
                    begin
                        slot_reg     <= s_tuser;
                        target_reg   <= s_tdata[TGT_W-1:0];
                        best_err_reg <= s_tdata[TGT_W-1:0];
                        best_m_reg   <= M_W'(1);
                        best_n_reg   <= N_W'(1);
                        r_reg        <= '0;
                        n_reg        <= N_W'(1);
                        state_reg    <= ST_RSCAN;
                    end
                end

                // post divider scan, no fit leaves r at R_MAX + 1
                ST_RSCAN:
                begin
                    if (vco_fit)
                    begin
                        state_reg <= ST_PREP;
                    end
                    else
                    begin
                        r_reg <= r_reg + R_W'(1);
                        if (r_reg == R_W'(R_MAX))
                        begin
                            state_reg <= ST_PREP;
                        end
                    end
                end

                // load the m quotient division
                ST_PREP:
                begin
                    div_num_reg <= DIV_W'(num_a) << (DIV_W - A_W);
                    div_den_reg <= DEN_W'(ref_eff);
                    div_rem_reg <= '0;
                    div_cnt_reg <= CNT_W'(A_W);
                    state_reg   <= ST_DIV1;
                end

                ST_DIV1, ST_DIV2:
                begin
                    div_num_reg <= {div_num_reg[DIV_W-2:0], div_bit};
                    div_rem_reg <= div_bit ? div_diff[DEN_W-1:0] : div_shift[DEN_W-1:0];
                    div_cnt_reg <= div_cnt_reg - CNT_W'(1);
                    if (div_cnt_reg == CNT_W'(1))
                    begin
                        state_reg <= (state_reg == ST_DIV1) ? ST_CHECK : ST_SCORE;
                    end
                end

                // m in range: load the achieved frequency division, else next n
                ST_CHECK:
                begin
                    if (m_in_range)
                    begin
                        mp2_reg     <= mp2_cand;
                        div_num_reg <= DIV_W'(num_b) << (DIV_W - B_W);
                        div_den_reg <= den_b;
                        div_rem_reg <= '0;
                        div_cnt_reg <= CNT_W'(B_W);
                        state_reg   <= ST_DIV2;
                    end
                    else if (n_reg == N_W'(N_MAX))
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        n_reg     <= n_reg + N_W'(1);
                        state_reg <= ST_PREP;
                    end
                end

                // keep the strictly smaller error, then next n
                ST_SCORE:
                begin
                    if (err_better)
                    begin
                        best_err_reg <= err_e[TGT_W-1:0];
                        best_m_reg   <= M_W'(mp2_reg - MP_W'(2));
                        best_n_reg   <= n_reg;
                    end
                    if (n_reg == N_W'(N_MAX))
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        n_reg     <= n_reg + N_W'(1);
                        state_reg <= ST_PREP;
                    end
                end

                // hand the result to the output register once it is free
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        out_slot_reg <= slot_reg;
                        out_m_reg    <= best_m_reg;
                        out_n_reg    <= best_n_reg;
                        out_r_reg    <= r_reg;
                        out_err_reg  <= best_err_reg;
                        state_reg    <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // output packing
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_slot_reg;
    assign m_tdata  = OUT_TD_W'({out_err_reg, out_r_reg, out_n_reg, out_m_reg});

    // the kept error never exceeds the starting error of the target
    a_best_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (best_err_reg <= target_reg))
        else $error("best error above target");

    // a running division always has steps left
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV1 || state_reg == ST_DIV2) |-> (div_cnt_reg != '0))
        else $error("divider ran with zero count");

    // the divider index stays in range while the search runs
    a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREP || state_reg == ST_CHECK || state_reg == ST_SCORE)
        |-> (n_reg >= N_W'(1) && n_reg <= N_W'(N_MAX)))
        else $error("n out of range");

    // an accepted request starts the post divider scan from zero
    a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer |=> (state_reg == ST_RSCAN && r_reg == '0))
        else $error("request did not start scan");

    // a delivered post divider never exceeds the no-fit code
    a_r_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (out_r_reg <= R_W'(R_MAX + 1)))
        else $error("post divider out of range");

endmodule
